@@ rtl/nps_pkg.sv @@
// Package for the nearest point search block: sizes, request codes.
// No dependencies; imported by nearest_point_search_top.
package nps_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int DIST_BITS  = SQ_BITS + 1;
  localparam int OUT_IDX_BITS  = 8;
  localparam int OUT_DIST_BITS = 33;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

endpackage

@@ rtl/nearest_point_search_top.sv @@
// Nearest point search: point store in one synchronous RAM, linear scan per query.
// Depends on nps_pkg (sizes and request codes).
//
//  channel   direction  handshake                 word
//  --------  ---------  ------------------------  ---------------------------------------
//  request   in         in_valid_i / in_stall_o   req_type_i, coord_x_i, coord_y_i
//  result    out        out_valid_o / out_stall_i found_o, nearest_index_o,
//                                                 squared_distance_o, overflow_o
//
//  Clear and append leave the block idle; code 3 is taken and dropped.
//  A query reads the N stored points, one per cycle from the single read port,
//  passes them through the square and compare stages, sees the pipeline empty
//  and then enters its done state.
//  A query on an empty set goes straight to the done state.
//  Reset clears count, overflow and control; the RAM is not cleared, only written
//  entries are ever read.
//  A held result does not block new requests; a finished query waits in its done
//  state until the output register is free.
module nearest_point_search_top
  import nps_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      req_type_i,
  input  logic signed [COORD_BITS-1:0]    coord_x_i,
  input  logic signed [COORD_BITS-1:0]    coord_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [OUT_IDX_BITS-1:0]         nearest_index_o,
  output logic [OUT_DIST_BITS-1:0]        squared_distance_o,
  output logic                            overflow_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  // set bookkeeping
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic                full;

  // query point, held for the whole scan
  logic signed [COORD_BITS-1:0] qx_q, qy_q;

  // point RAM, {x, y} per entry
  logic [2*COORD_BITS-1:0] pt_mem [MAX_POINTS];
  logic                    mem_we;
  logic [2*COORD_BITS-1:0] rd_data_q;

  // scan pipeline
  logic [CNT_BITS-1:0] iss_q, iss_d;
  logic                issue;
  logic                p1_q;
  logic [IDX_BITS-1:0] p1_idx_q;
  logic                p2_q;
  logic [IDX_BITS-1:0] p2_idx_q;
  logic [SQ_BITS-1:0]  sqx_q, sqy_q;

  // running best
  logic                have_q, have_d;
  logic [IDX_BITS-1:0] best_i_q, best_i_d;
  logic [DIST_BITS-1:0] best_d_q, best_d_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic                     found_q;
  logic [OUT_IDX_BITS-1:0]  idx_q;
  logic [OUT_DIST_BITS-1:0] dist_q;
  logic                     ovf_out_q;
  logic                     out_load;

  logic in_acc;
  logic out_acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign full        = (cnt_q == CNT_BITS'(MAX_POINTS));
  assign mem_we      = in_acc && (req_type_i == REQ_APPEND) && !full;
  assign issue       = (state_q == ST_SCAN) && (iss_q < cnt_q);
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // RAM: one write port (append), one registered read port (scan)
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pt_mem[cnt_q[IDX_BITS-1:0]] <= {coord_x_i, coord_y_i};
    end
    if (issue) begin
      rd_data_q <= pt_mem[iss_q[IDX_BITS-1:0]];
    end
  end

  // square stage: diff and one multiply per axis
  logic signed [COORD_BITS-1:0]  rx, ry;
  logic signed [DIFF_BITS-1:0]   dx, dy;
  logic signed [2*DIFF_BITS-1:0] dx2, dy2;

  assign rx  = rd_data_q[2*COORD_BITS-1:COORD_BITS];
  assign ry  = rd_data_q[COORD_BITS-1:0];
  assign dx  = DIFF_BITS'(qx_q) - DIFF_BITS'(rx);
  assign dy  = DIFF_BITS'(qy_q) - DIFF_BITS'(ry);
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qx_q <= coord_x_i;
      qy_q <= coord_y_i;
    end
    if (issue) begin
      p1_idx_q <= iss_q[IDX_BITS-1:0];
    end
    if (p1_q) begin
      p2_idx_q <= p1_idx_q;
      sqx_q    <= dx2[SQ_BITS-1:0];
      sqy_q    <= dy2[SQ_BITS-1:0];
    end
  end

  // compare stage; strict less keeps the earliest point on a tie
  logic [DIST_BITS-1:0] sum_d;
  assign sum_d = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    iss_d       = iss_q;
    have_d      = have_q;
    best_i_d    = best_i_q;
    best_d_d    = best_d_q;
    out_valid_d = out_valid_q;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_CLEAR: begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
            REQ_APPEND: begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                cnt_d = cnt_q + CNT_BITS'(1);
              end
            end
            REQ_QUERY: begin
              iss_d  = '0;
              have_d = 1'b0;
              state_d = (cnt_q == '0) ? ST_DONE : ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          iss_d = iss_q + CNT_BITS'(1);
        end
        if (p2_q && (!have_q || sum_d < best_d_q)) begin
          have_d   = 1'b1;
          best_i_d = p2_idx_q;
          best_d_d = sum_d;
        end
        if (!issue && !p1_q && !p2_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      iss_q       <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      iss_q       <= iss_d;
      p1_q        <= issue;
      p2_q        <= p1_q;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_i_q <= best_i_d;
    best_d_q <= best_d_d;
    if (out_load) begin
      found_q   <= have_q;
      idx_q     <= have_q ? OUT_IDX_BITS'(best_i_q) : '0;
      dist_q    <= have_q ? OUT_DIST_BITS'(best_d_q) : '0;
      ovf_out_q <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = found_q;
  assign nearest_index_o    = idx_q;
  assign squared_distance_o = dist_q;
  assign overflow_o         = ovf_out_q;

  // the scan pipeline is empty whenever new requests are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!p1_q && !p2_q))
    else $error("scan pipeline busy while idle");

  // the fill count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(MAX_POINTS))
    else $error("point count beyond capacity");

  // reads never pass the last written entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q <= cnt_q))
    else $error("scan read past fill count");

  // a non-empty set always yields a best point by the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && cnt_q != '0) |-> have_q)
    else $error("query finished without a candidate");

  // a not-found word carries zero index and distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (idx_q == '0 && dist_q == '0))
    else $error("not-found word with nonzero payload");

endmodule
